/* src/ayd_pkg.sv */
// ----------------------------------------------------------------------------
// ayd_pkg: shared types, constants and calendar functions
// Field widths, Gregorian calendar tables and the constant-reciprocal
// factor used to divide a year by 100 without a divider.
// ----------------------------------------------------------------------------
package ayd_pkg;

    localparam int unsigned YEAR_W  = 14;
    localparam int unsigned MON_W   = 4;
    localparam int unsigned DAY_W   = 5;
    localparam int unsigned SEC_W   = 17;
    localparam int unsigned DOY_W   = 9;
    localparam int unsigned AGE_Y_W = 13;
    localparam int unsigned AGE_D_W = 9;

    localparam logic [YEAR_W-1:0] YEAR_MIN = 14'd1;
    localparam logic [YEAR_W-1:0] YEAR_MAX = 14'd9999;
    localparam logic [SEC_W-1:0]  SEC_MAX  = 17'd86399;

    localparam logic [MON_W-1:0] MON_JAN = 4'd1;
    localparam logic [MON_W-1:0] MON_FEB = 4'd2;
    localparam logic [MON_W-1:0] MON_MAR = 4'd3;
    localparam logic [MON_W-1:0] MON_APR = 4'd4;
    localparam logic [MON_W-1:0] MON_MAY = 4'd5;
    localparam logic [MON_W-1:0] MON_JUN = 4'd6;
    localparam logic [MON_W-1:0] MON_JUL = 4'd7;
    localparam logic [MON_W-1:0] MON_AUG = 4'd8;
    localparam logic [MON_W-1:0] MON_SEP = 4'd9;
    localparam logic [MON_W-1:0] MON_OCT = 4'd10;
    localparam logic [MON_W-1:0] MON_NOV = 4'd11;
    localparam logic [MON_W-1:0] MON_DEC = 4'd12;

    localparam logic [DAY_W-1:0] DAY_FIRST = 5'd1;
    localparam logic [DAY_W-1:0] DAY_LEAP  = 5'd29;

    // floor(y / 100) = (y * 20972) >> 21, exact for y below 43690
    localparam int unsigned       DIV100_MUL_W = 15;
    localparam logic [14:0]       DIV100_MUL   = 15'd20972;
    localparam int unsigned       DIV100_SHIFT = 21;
    localparam int unsigned       Q100_W       = 8;
    localparam logic [6:0]        CENTURY      = 7'd100;

    localparam logic [DOY_W-1:0] YEAR_DAYS      = 9'd365;
    localparam logic [DOY_W-1:0] LEAP_YEAR_DAYS = 9'd366;

    typedef struct packed {
        logic [YEAR_W-1:0] year;
        logic [MON_W-1:0]  month;
        logic [DAY_W-1:0]  day;
        logic [SEC_W-1:0]  sec;
    } t_stamp;

    // Length of a month; zero for a month code that means nothing
    function automatic logic [DAY_W-1:0] month_days(input logic [MON_W-1:0] m,
                                                    input logic leap);
        logic [DAY_W-1:0] len;
        case (m)
            MON_JAN, MON_MAR, MON_MAY, MON_JUL,
            MON_AUG, MON_OCT, MON_DEC: len = 5'd31;
            MON_APR, MON_JUN, MON_SEP, MON_NOV: len = 5'd30;
            MON_FEB: len = leap ? 5'd29 : 5'd28;
            default: len = 5'd0;
        endcase
        return len;
    endfunction

    // Days in the common year before the first of month m
    function automatic logic [DOY_W-1:0] days_before(input logic [MON_W-1:0] m);
        logic [DOY_W-1:0] n;
        case (m)
            MON_JAN: n = 9'd0;
            MON_FEB: n = 9'd31;
            MON_MAR: n = 9'd59;
            MON_APR: n = 9'd90;
            MON_MAY: n = 9'd120;
            MON_JUN: n = 9'd151;
            MON_JUL: n = 9'd181;
            MON_AUG: n = 9'd212;
            MON_SEP: n = 9'd243;
            MON_OCT: n = 9'd273;
            MON_NOV: n = 9'd304;
            MON_DEC: n = 9'd334;
            default: n = 9'd0;
        endcase
        return n;
    endfunction

endpackage

/* src/age_years_days_calc.sv */
// ----------------------------------------------------------------------------
// age_years_days_calc: completed years and days since a birth date
// Checks both timestamps, rejects future births and ages over the limit,
// and reports the age in years plus days since the last anniversary.
// ----------------------------------------------------------------------------
// Pipeline: an accepted beat passes the input, range, date, anniversary and
//   result registers in that order; o_done is registered with the result.
// Throughput: one beat per cycle while o_busy is low, set by the five-stage pipeline.
// Reset: synchronous, clears all valid flags; o_busy stays high during reset
//   and until the live flag is set after it, and is low from then on.
// The receiver cannot stall: each result is shown for exactly one cycle.
// ----------------------------------------------------------------------------
module age_years_days_calc #(
    parameter int unsigned MAX_AGE_YEARS = 5000
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [ayd_pkg::YEAR_W-1:0]  i_birth_year,
    input  logic [ayd_pkg::MON_W-1:0]   i_birth_month,
    input  logic [ayd_pkg::DAY_W-1:0]   i_birth_day,
    input  logic [ayd_pkg::SEC_W-1:0]   i_birth_second_of_day,
    input  logic [ayd_pkg::YEAR_W-1:0]  i_now_year,
    input  logic [ayd_pkg::MON_W-1:0]   i_now_month,
    input  logic [ayd_pkg::DAY_W-1:0]   i_now_day,
    input  logic [ayd_pkg::SEC_W-1:0]   i_now_second_of_day,
    output logic                        o_busy,
    output logic                        o_done,
    output logic [ayd_pkg::AGE_Y_W-1:0] o_age_years,
    output logic [ayd_pkg::AGE_D_W-1:0] o_age_days,
    output logic                        o_bad_timestamp
);
    import ayd_pkg::*;

    localparam int unsigned VLD_STAGES = 4;
    localparam int unsigned DIFF_W     = DOY_W + 1;

    typedef struct packed {
        t_stamp birth;
        t_stamp now;
        logic   birth_rng_ok;
        logic   now_rng_ok;
    } t_stage_a;

    typedef struct packed {
        logic              bad;
        logic              feb29;
        logic              leap_now;
        logic              leap_prev;
        logic [YEAR_W-1:0] birth_year;
        logic [MON_W-1:0]  birth_month;
        logic [DAY_W-1:0]  birth_day;
        logic [YEAR_W-1:0] now_year;
        logic [MON_W-1:0]  now_month;
        logic [DAY_W-1:0]  now_day;
        logic [DOY_W-1:0]  doy_now;
    } t_stage_b;

    typedef struct packed {
        logic              bad;
        logic              step_back;
        logic [YEAR_W-1:0] years;
        logic [DOY_W-1:0]  doy_ann;
        logic [DOY_W-1:0]  doy_now;
        logic [DOY_W-1:0]  prev_len;
    } t_stage_c;

    logic                  accept;
    logic                  r_live;
    logic [VLD_STAGES-1:0] r_vld;
    logic                  r_done;
    t_stamp                r_birth;
    t_stamp                r_now;
    t_stage_a              n_a, r_a;
    t_stage_b              n_b, r_b;
    t_stage_c              n_c, r_c;
    logic [AGE_Y_W-1:0]    n_years, r_years;
    logic [AGE_D_W-1:0]    n_days, r_days;
    logic                  n_bad, r_bad;
    logic                  leap_birth, leap_now, leap_prev;
    logic [YEAR_W-1:0]     prev_year;

    assign accept = i_start && !o_busy;

    // control: live flag and valid shift line
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_live <= 1'b0;
            r_vld  <= '0;
            r_done <= 1'b0;
        end else begin
            r_live <= 1'b1;
            r_vld  <= {r_vld[VLD_STAGES-2:0], accept};
            r_done <= r_vld[VLD_STAGES-1];
        end
    end

    // capture the input beat
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_birth <= '{i_birth_year, i_birth_month, i_birth_day,
                         i_birth_second_of_day};
            r_now   <= '{i_now_year, i_now_month, i_now_day, i_now_second_of_day};
        end
    end

    // leap flags of birth year, current year and the year before
    assign prev_year = r_now.year - YEAR_W'(1);

    ayd_leap u_leap_birth (.i_clk(i_clk), .i_year(r_birth.year), .o_leap(leap_birth));
    ayd_leap u_leap_now   (.i_clk(i_clk), .i_year(r_now.year),   .o_leap(leap_now));
    ayd_leap u_leap_prev  (.i_clk(i_clk), .i_year(prev_year),    .o_leap(leap_prev));

    // stage A: field range checks
    always_comb begin
        n_a.birth        = r_birth;
        n_a.now          = r_now;
        n_a.birth_rng_ok = (r_birth.year >= YEAR_MIN) && (r_birth.year <= YEAR_MAX) &&
                           (r_birth.month >= MON_JAN) && (r_birth.month <= MON_DEC) &&
                           (r_birth.day >= DAY_FIRST) && (r_birth.sec <= SEC_MAX);
        n_a.now_rng_ok   = (r_now.year >= YEAR_MIN) && (r_now.year <= YEAR_MAX) &&
                           (r_now.month >= MON_JAN) && (r_now.month <= MON_DEC) &&
                           (r_now.day >= DAY_FIRST) && (r_now.sec <= SEC_MAX);
    end

    always_ff @(posedge i_clk) begin
        r_a <= n_a;
    end

    // stage B: month length, future birth, day of year of now
    always_comb begin
        logic birth_ok;
        logic now_ok;
        logic future;
        birth_ok = r_a.birth_rng_ok &&
                   (r_a.birth.day <= month_days(r_a.birth.month, leap_birth));
        now_ok   = r_a.now_rng_ok &&
                   (r_a.now.day <= month_days(r_a.now.month, leap_now));
        future   = (r_a.birth > r_a.now);
        n_b.bad         = !birth_ok || !now_ok || future;
        n_b.feb29       = (r_a.birth.month == MON_FEB) && (r_a.birth.day == DAY_LEAP);
        n_b.leap_now    = leap_now;
        n_b.leap_prev   = leap_prev;
        n_b.birth_year  = r_a.birth.year;
        n_b.birth_month = r_a.birth.month;
        n_b.birth_day   = r_a.birth.day;
        n_b.now_year    = r_a.now.year;
        n_b.now_month   = r_a.now.month;
        n_b.now_day     = r_a.now.day;
        n_b.doy_now     = days_before(r_a.now.month) +
                          DOY_W'((r_a.now.month > MON_FEB) && leap_now) +
                          DOY_W'(r_a.now.day);
    end

    always_ff @(posedge i_clk) begin
        r_b <= n_b;
    end

    // stage C: pick the last anniversary and its day of year
    always_comb begin
        logic [MON_W-1:0] cur_m;
        logic [DAY_W-1:0] cur_d;
        logic             step;
        logic             ann_leap;
        logic             shift;
        logic [MON_W-1:0] ann_m;
        logic [DAY_W-1:0] ann_d;
        cur_m    = (r_b.feb29 && !r_b.leap_now) ? MON_MAR : r_b.birth_month;
        cur_d    = (r_b.feb29 && !r_b.leap_now) ? DAY_FIRST : r_b.birth_day;
        step     = (cur_m > r_b.now_month) ||
                   ((cur_m == r_b.now_month) && (cur_d > r_b.now_day));
        ann_leap = step ? r_b.leap_prev : r_b.leap_now;
        shift    = r_b.feb29 && !ann_leap;
        ann_m    = shift ? MON_MAR : r_b.birth_month;
        ann_d    = shift ? DAY_FIRST : r_b.birth_day;
        n_c.bad       = r_b.bad;
        n_c.step_back = step;
        n_c.years     = r_b.now_year - r_b.birth_year - YEAR_W'(step);
        n_c.doy_ann   = days_before(ann_m) + DOY_W'((ann_m > MON_FEB) && ann_leap) +
                        DOY_W'(ann_d);
        n_c.doy_now   = r_b.doy_now;
        n_c.prev_len  = r_b.leap_prev ? LEAP_YEAR_DAYS : YEAR_DAYS;
    end

    always_ff @(posedge i_clk) begin
        r_c <= n_c;
    end

    // stage D: day count, age limit, zero on error
    always_comb begin
        logic [DIFF_W-1:0] days;
        logic              too_old;
        if (r_c.step_back) begin
            days = DIFF_W'(r_c.prev_len) - DIFF_W'(r_c.doy_ann) + DIFF_W'(r_c.doy_now);
        end else begin
            days = DIFF_W'(r_c.doy_now) - DIFF_W'(r_c.doy_ann);
        end
        too_old = (r_c.years > YEAR_W'(MAX_AGE_YEARS));
        n_bad   = r_c.bad || too_old;
        n_years = n_bad ? '0 : r_c.years[AGE_Y_W-1:0];
        n_days  = n_bad ? '0 : days[AGE_D_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        r_years <= n_years;
        r_days  <= n_days;
        r_bad   <= n_bad;
    end

    assign o_busy          = !r_live;
    assign o_done          = r_done;
    assign o_age_years     = r_years;
    assign o_age_days      = r_days;
    assign o_bad_timestamp = r_bad;

    // every accepted beat gives a result once it leaves the pipeline
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |-> ##5 o_done)
        else $error("accepted beat produced no result");

    // no result without a matching accepted beat before it
    a_no_phantom: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(accept, 5))
        else $error("result without an accepted beat");

    // an error result carries zero age
    a_bad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_bad_timestamp) |-> (o_age_years == '0 && o_age_days == '0))
        else $error("error result with nonzero age");

    // days since anniversary never exceed a common year
    a_days_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (o_age_days <= AGE_D_W'(YEAR_DAYS)))
        else $error("day count out of range");

endmodule

/* src/ayd_leap.sv */
// ----------------------------------------------------------------------------
// ayd_leap: Gregorian leap-year flag
// Divides the year by 100 through a constant reciprocal, registers the
// quotient with the year, then tests the 4-year, century and 400-year rules.
// ----------------------------------------------------------------------------
module ayd_leap (
    input  logic                       i_clk,
    input  logic [ayd_pkg::YEAR_W-1:0] i_year,
    output logic                       o_leap
);
    import ayd_pkg::*;

    localparam int unsigned PROD_W = YEAR_W + DIV100_MUL_W;

    logic [PROD_W-1:0] prod;
    logic [Q100_W-1:0] n_q100;
    logic [Q100_W-1:0] r_q100;
    logic [YEAR_W-1:0] r_year;
    logic [YEAR_W:0]   cent_back;
    logic              century;

    // divide by 100 with the reciprocal multiply
    assign prod   = PROD_W'(i_year) * PROD_W'(DIV100_MUL);
    assign n_q100 = prod[DIV100_SHIFT +: Q100_W];

    // hold year and quotient for the rule check
    always_ff @(posedge i_clk) begin
        r_year <= i_year;
        r_q100 <= n_q100;
    end

    // century when the quotient times 100 gives the year back
    assign cent_back = (YEAR_W+1)'(r_q100) * (YEAR_W+1)'(CENTURY);
    assign century   = (cent_back == {1'b0, r_year});
    assign o_leap    = (r_year[1:0] == 2'b00) && (!century || (r_q100[1:0] == 2'b00));

endmodule
